### src/bfhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfhp_pkg: shared types and constants
// Item structs, request codes, filter commands and hash constants for the
// Bloom filter hit predictor.
// ----------------------------------------------------------------------------
package bfhp_pkg;

  localparam int NUM_HASH   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int COUNT_W    = 21;

  // request codes
  localparam logic [1:0] REQ_PREDICT = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b1;

  // hash constants
  localparam logic [63:0] MIX_A_XOR = 64'h0000_0000_dead_beef;
  localparam logic [63:0] MIX_B_XOR = 64'd61;
  localparam logic [63:0] MIX_C_XOR = 64'h0000_0000_00c0_ffee;
  localparam logic [63:0] MIX_D_XOR = 64'h0000_0000_dead_cafe;
  // lane 0 has no multiply
  localparam logic [31:0] MIX_MUL [NUM_HASH] = '{32'd0, 32'h27d4_eb2d,
                                                  32'h05a1_7d2d, 32'h6d2b_79a5};
  localparam int MIX_SHR [NUM_HASH] = '{13, 15, 17, 14};

  typedef logic [NUM_HASH-1:0][63:0] hash_vec_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
    logic        actual_hit;
  } in_item_t;

  typedef struct packed {
    logic present;
    logic was_cleared;
  } out_item_t;

  typedef enum logic [1:0] {
    FOP_NONE,
    FOP_LOOKUP,
    FOP_INSERT,
    FOP_CLEAR
  } filt_op_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic present;
  } filt_stat_t;

endpackage : bfhp_pkg
`default_nettype wire

### src/bloom_filter_hit_predictor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_hit_predictor_core: four-hash Bloom filter hit predictor
// Predicts hits on an address; updates insert real hits; clears on request
// or when the insertion count passes max_entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input: raise start with in_item; the item is taken on an edge where
//   start is high and busy is low. Each item gives exactly one result on
//   out_item, shown for one cycle with out_valid. The receiver cannot stall.
//   Config: cfg_we with cfg_index (0 enable, 1 max_entries) and cfg_wdata,
//   written only while busy is low and no result is pending; this is the
//   user's duty, the block itself does not enforce it.
// Path from accept to out_valid, FILTER_BITS a power of two:
//   predict or non-inserting update: 4-stage hash pipeline, reduction,
//   4 pipelined filter word reads; inserting update: all that, then a
//   read-modify-write of 4 words through the single memory port pair.
//   Other FILTER_BITS: the reduction is the 16-step remainder unit.
//   Clear request, disabled or unused request: result the cycle after accept.
// One item is in flight at a time; the next is taken in the cycle its result
// shows. A clear (requested, or by count overflow) then keeps busy high
// while the memory is swept one word a cycle.
// Reset: busy for the same sweep; enable resets to 1, max_entries to 1024.
// ----------------------------------------------------------------------------
module bloom_filter_hit_predictor_core
  import bfhp_pkg::*;
#(
  parameter int FILTER_BITS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item input
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  // result output
  output logic                  out_valid,
  output out_item_t             out_item,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(FILTER_BITS);

  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_CALC,
    T_LOOK,
    T_INS
  } tstate_t;

  tstate_t                     state_r;
  logic                        enable_r;
  logic [CFG_DATA_W-1:0]       max_entries_r;
  logic [COUNT_W-1:0]          count_r;
  logic                        ins_r;
  logic                        out_valid_r;
  out_item_t                   out_item_r;

  logic                        hash_start;
  logic                        hash_done;
  hash_vec_t                   hash;
  logic                        mod_done;
  logic [NUM_HASH-1:0][PW-1:0] pos;
  filt_op_t                    fcmd;
  filt_stat_t                  fstat;
  logic [COUNT_W-1:0]          cnt_inc;
  logic                        overflow;
  logic                        lookup_req;

  bfhp_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_item.address),
    .done  (hash_done),
    .hash  (hash)
  );

  bfhp_mod #(
    .FILTER_BITS (FILTER_BITS)
  ) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_done),
    .hash_i (hash),
    .done   (mod_done),
    .pos    (pos)
  );

  bfhp_filter #(
    .FILTER_BITS (FILTER_BITS)
  ) u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fcmd),
    .pos_i (pos),
    .stat  (fstat)
  );

  assign cnt_inc    = count_r + 1'b1;
  assign overflow   = cnt_inc > {1'b0, max_entries_r};
  assign lookup_req = enable_r &&
                      ((in_item.req_type == REQ_PREDICT) ||
                       (in_item.req_type == REQ_UPDATE));

  // filter commands and hash launch
  always_comb begin
    fcmd       = FOP_NONE;
    hash_start = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (start) begin
          if (in_item.req_type == REQ_CLEAR) begin
            fcmd = FOP_CLEAR;
          end else if (lookup_req) begin
            hash_start = 1'b1;
          end
        end
      end
      T_CALC: begin
        if (mod_done) begin
          fcmd = FOP_LOOKUP;
        end
      end
      T_LOOK: begin
        if (fstat.done && ins_r && !fstat.present) begin
          fcmd = FOP_INSERT;
        end
      end
      T_INS: begin
        if (fstat.done && overflow) begin
          fcmd = FOP_CLEAR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        T_CLEAR: begin
          if (!fstat.busy) begin
            state_r <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (start) begin
            ins_r <= (in_item.req_type == REQ_UPDATE) && in_item.actual_hit;
            if (in_item.req_type == REQ_CLEAR) begin
              count_r                <= '0;
              out_valid_r            <= 1'b1;
              out_item_r.present     <= 1'b0;
              out_item_r.was_cleared <= 1'b1;
              state_r                <= T_CLEAR;
            end else if (lookup_req) begin
              state_r <= T_CALC;
            end else begin
              // disabled or unused request: empty result
              out_valid_r            <= 1'b1;
              out_item_r.present     <= 1'b0;
              out_item_r.was_cleared <= 1'b0;
            end
          end
        end
        T_CALC: begin
          if (mod_done) begin
            state_r <= T_LOOK;
          end
        end
        T_LOOK: begin
          if (fstat.done) begin
            if (ins_r && !fstat.present) begin
              state_r <= T_INS;
            end else begin
              out_valid_r            <= 1'b1;
              out_item_r.present     <= fstat.present;
              out_item_r.was_cleared <= 1'b0;
              state_r                <= T_IDLE;
            end
          end
        end
        T_INS: begin
          if (fstat.done) begin
            out_valid_r        <= 1'b1;
            out_item_r.present <= 1'b0;
            if (overflow) begin
              count_r                <= '0;
              out_item_r.was_cleared <= 1'b1;
              state_r                <= T_CLEAR;
            end else begin
              count_r                <= cnt_inc;
              out_item_r.was_cleared <= 1'b0;
              state_r                <= T_IDLE;
            end
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b1;
      max_entries_r <= CFG_DATA_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:      enable_r      <= cfg_wdata[0];
        CFG_MAX_ENTRIES: max_entries_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy      = (state_r != T_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule : bloom_filter_hit_predictor_core
`default_nettype wire

### src/bfhp_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfhp_hash: four-lane mix hash pipeline
// Four register stages; 64-bit multiplies split into two 32-bit partials.
// ----------------------------------------------------------------------------
module bfhp_hash
  import bfhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output hash_vec_t   hash
);

  logic [2:0]                 vld_r;
  logic                       done_r;
  hash_vec_t                  s1_r, s1_nxt;
  hash_vec_t                  s2_r, s2_nxt;
  hash_vec_t                  s3_lo_r, s3_lo_nxt;
  logic [NUM_HASH-1:0][31:0]  s3_hi_r, s3_hi_nxt;
  hash_vec_t                  s4_r, s4_nxt;

  always_comb begin : mix_stages
    logic [63:0] t;
    logic [63:0] x;
    // stage 1: seed xor and a first shift-add (shift-xor in lane 1)
    s1_nxt[0] = (key ^ MIX_A_XOR) + (key << 4);
    s1_nxt[1] = (key ^ MIX_B_XOR) ^ (key >> 16);
    s1_nxt[2] = (key ^ MIX_C_XOR) + (key << 5);
    s1_nxt[3] = (key ^ MIX_D_XOR) + (key << 6);
    // stage 2
    t         = s1_r[0] ^ (s1_r[0] >> 10);
    s2_nxt[0] = t + (t << 7);
    t         = s1_r[1] + (s1_r[1] << 3);
    s2_nxt[1] = t ^ (t >> 4);
    s2_nxt[2] = s1_r[2] ^ (s1_r[2] >> 11);
    s2_nxt[3] = s1_r[3] ^ (s1_r[3] >> 9);
    // stage 3: partial products, low and high half of the stage 2 word
    s3_lo_nxt[0] = s2_r[0];
    s3_hi_nxt[0] = 32'd0;
    for (int l = 1; l < NUM_HASH; l++) begin
      s3_lo_nxt[l] = 64'(s2_r[l][31:0]) * 64'(MIX_MUL[l]);
      s3_hi_nxt[l] = s2_r[l][63:32] * MIX_MUL[l];
    end
    // stage 4: combine, final xor-shift
    for (int l = 0; l < NUM_HASH; l++) begin
      x         = s3_lo_r[l] + {s3_hi_r[l], 32'd0};
      s4_nxt[l] = x ^ (x >> MIX_SHR[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      done_r <= 1'b0;
    end else begin
      vld_r  <= {vld_r[1:0], start};
      done_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= s1_nxt;
    s2_r    <= s2_nxt;
    s3_lo_r <= s3_lo_nxt;
    s3_hi_r <= s3_hi_nxt;
    s4_r    <= s4_nxt;
  end

  assign done = done_r;
  assign hash = s4_r;

endmodule : bfhp_hash
`default_nettype wire

### src/bfhp_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfhp_mod: hash to bit position reduction
// Power-of-two size: registered low bits. Otherwise a four-lane restoring
// remainder unit, four bits a cycle.
// ----------------------------------------------------------------------------
module bfhp_mod
  import bfhp_pkg::*;
#(
  parameter  int FILTER_BITS = 4096,
  localparam int PW          = $clog2(FILTER_BITS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  hash_vec_t                  hash_i,
  output logic                       done,
  output logic [NUM_HASH-1:0][PW-1:0] pos
);

  localparam bit IS_POW2 = (FILTER_BITS & (FILTER_BITS - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      logic                        done_r;
      logic [NUM_HASH-1:0][PW-1:0] pos_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          for (int l = 0; l < NUM_HASH; l++) begin
            pos_r[l] <= hash_i[l][PW-1:0];
          end
        end
      end

      assign done = done_r;
      assign pos  = pos_r;
    end else begin : g_div
      localparam int DIGIT_BITS = 4;
      localparam int STEPS      = 64 / DIGIT_BITS;
      localparam int CW         = $clog2(STEPS);
      localparam logic [PW:0]   N_EXT = (PW + 1)'(FILTER_BITS);
      localparam logic [CW-1:0] LAST  = CW'(STEPS - 1);

      hash_vec_t                   sh_r;
      logic [NUM_HASH-1:0][PW-1:0] rem_r, rem_nxt;
      logic [CW-1:0]               cnt_r;
      logic                        run_r;
      logic                        done_r;

      always_comb begin : rem_step
        logic [PW:0]   t;
        logic [PW-1:0] acc;
        for (int l = 0; l < NUM_HASH; l++) begin
          acc = rem_r[l];
          for (int d = 0; d < DIGIT_BITS; d++) begin
            t = {acc, sh_r[l][63-d]};
            if (t >= N_EXT) begin
              t = t - N_EXT;
            end
            acc = t[PW-1:0];
          end
          rem_nxt[l] = acc;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r  <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            run_r <= 1'b1;
            cnt_r <= '0;
          end else if (run_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == LAST) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          sh_r  <= hash_i;
          rem_r <= '0;
        end else if (run_r) begin
          for (int l = 0; l < NUM_HASH; l++) begin
            sh_r[l] <= sh_r[l] << DIGIT_BITS;
          end
          rem_r <= rem_nxt;
        end
      end

      assign done = done_r;
      assign pos  = rem_r;
    end
  endgenerate

endmodule : bfhp_mod
`default_nettype wire

### src/bfhp_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfhp_filter: filter bit memory and its sequencer
// 64-bit words, one read and one write port. Lookup reads four words,
// insert does read-modify-write per position, clear sweeps every word.
// ----------------------------------------------------------------------------
module bfhp_filter
  import bfhp_pkg::*;
#(
  parameter  int FILTER_BITS = 4096,
  localparam int PW          = $clog2(FILTER_BITS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  filt_op_t                    cmd,
  input  logic [NUM_HASH-1:0][PW-1:0] pos_i,
  output filt_stat_t                  stat
);

  localparam int WORDS = (FILTER_BITS + 63) / 64;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  typedef enum logic [2:0] {
    F_CLEAR,
    F_IDLE,
    F_LOOK,
    F_INS_RD,
    F_INS_WR
  } fstate_t;

  fstate_t                     state_r;
  logic [NUM_HASH-1:0][PW-1:0] pos_r;
  logic [2:0]                  step_r;
  logic [5:0]                  bsel_r;
  logic [WAW-1:0]              wa_r;
  logic [WAW-1:0]              clr_r;
  logic                        all_r;
  logic                        done_r;
  logic                        present_r;

  logic [63:0]    mem [WORDS];
  logic [63:0]    rd_data_r;
  logic [PW-1:0]  cur_pos;
  logic           rd_en;
  logic [WAW-1:0] rd_addr;
  logic           wr_en;
  logic [WAW-1:0] wr_addr;
  logic [63:0]    wr_data;
  logic           hit_bit;

  always_comb begin
    cur_pos = pos_r[step_r[1:0]];
    rd_en   = ((state_r == F_LOOK) && !step_r[2]) || (state_r == F_INS_RD);
    rd_addr = WAW'(cur_pos >> 6);
    hit_bit = rd_data_r[bsel_r];
    wr_en   = (state_r == F_INS_WR) || (state_r == F_CLEAR);
    wr_addr = (state_r == F_CLEAR) ? clr_r : wa_r;
    wr_data = (state_r == F_CLEAR) ? 64'd0 : (rd_data_r | (64'd1 << bsel_r));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_CLEAR;
      clr_r   <= '0;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        F_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_WORD) begin
            state_r <= F_IDLE;
          end
        end
        F_IDLE: begin
          step_r <= '0;
          all_r  <= 1'b1;
          pos_r  <= pos_i;
          case (cmd)
            FOP_LOOKUP: state_r <= F_LOOK;
            FOP_INSERT: state_r <= F_INS_RD;
            FOP_CLEAR: begin
              clr_r   <= '0;
              state_r <= F_CLEAR;
            end
            default: ;
          endcase
        end
        F_LOOK: begin
          // read issued at step s, checked at step s+1
          if (!step_r[2]) begin
            bsel_r <= cur_pos[5:0];
          end
          if (step_r != 3'd0) begin
            all_r <= all_r & hit_bit;
          end
          step_r <= step_r + 1'b1;
          if (step_r[2]) begin
            done_r    <= 1'b1;
            present_r <= all_r & hit_bit;
            state_r   <= F_IDLE;
          end
        end
        F_INS_RD: begin
          bsel_r  <= cur_pos[5:0];
          wa_r    <= rd_addr;
          state_r <= F_INS_WR;
        end
        F_INS_WR: begin
          step_r <= step_r + 1'b1;
          if (step_r[1:0] == 2'd3) begin
            done_r  <= 1'b1;
            state_r <= F_IDLE;
          end else begin
            state_r <= F_INS_RD;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign stat.busy    = (state_r != F_IDLE);
  assign stat.done    = done_r;
  assign stat.present = present_r;

endmodule : bfhp_filter
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bloom_filter_hit_predictor_core
// Feeds predict, update, clear and unused requests through the start/busy
// port, rewrites enable and max_entries between phases, and checks every
// result against a bit-accurate filter model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import bfhp_pkg::*;

  localparam int FILTER_BITS   = 4096;
  // unused request code, not named in the package
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // consecutive idle cycles seen before a register write or a pause ends
  localparam int SETTLE_CYCLES = 4;
  // tail after the last result: one full sweep plus an item's latency
  localparam int TAIL_CYCLES   = 120;
  // worst gap between accepts in a correct run: the sender gap, an inserting
  // item's latency, a full sweep and the settle count; the limit lies far
  // above that sum
  localparam int STALL_LIMIT   = 2000;
  localparam int POOL_SIZE     = 16;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 50;

  // hash constants of the four lanes
  localparam logic [63:0] LANE0_XOR = 64'hdead_beef;
  localparam logic [63:0] LANE1_XOR = 64'd61;
  localparam logic [63:0] LANE2_XOR = 64'hc0_ffee;
  localparam logic [63:0] LANE3_XOR = 64'hdead_cafe;
  localparam logic [63:0] LANE1_MUL = 64'h27d4_eb2d;
  localparam logic [63:0] LANE2_MUL = 64'h05a1_7d2d;
  localparam logic [63:0] LANE3_MUL = 64'h6d2b_79a5;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    in_item_t              item;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } step_t;

  typedef struct {
    out_item_t res;
    int        seq;
    in_item_t  src;
  } outcome_t;

  // DUT ports; the inputs are all known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // filter model state and its register copies
  logic [FILTER_BITS-1:0] filt_m  = '0;
  logic [COUNT_W-1:0]     count_m = '0;
  logic                   en_m    = 1'b1;
  logic [CFG_DATA_W-1:0]  max_m   = 20'd1024;

  step_t    step_q[$];      // pending items, register writes and pauses
  outcome_t outcome_q[$];   // predicted results, oldest first
  logic [63:0] addr_pool [POOL_SIZE];

  int items_taken   = 0;    // NBA-updated by driver
  int outcomes_seen = 0;    // NBA-updated by monitor
  int err_cnt       = 0;
  int idle_run      = 0;
  int gap_left      = 0;
  int burst_left    = 0;
  int stall_cyc     = 0;

  bloom_filter_hit_predictor_core #(
    .FILTER_BITS(FILTER_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Filter model
  // --------------------------------------------------------------------------

  // 64-bit mix of one hash lane; all arithmetic wraps at 64 bits
  function automatic logic [63:0] lane_hash(int lane, logic [63:0] key);
    logic [63:0] k;
    k = key;
    case (lane)
      0: begin
        k = (k ^ LANE0_XOR) + (k << 4);
        k = k ^ (k >> 10);
        k = k + (k << 7);
        k = k ^ (k >> 13);
      end
      1: begin
        k = (k ^ LANE1_XOR) ^ (k >> 16);
        k = k + (k << 3);
        k = k ^ (k >> 4);
        k = k * LANE1_MUL;
        k = k ^ (k >> 15);
      end
      2: begin
        k = (k ^ LANE2_XOR) + (k << 5);
        k = k ^ (k >> 11);
        k = k * LANE2_MUL;
        k = k ^ (k >> 17);
      end
      default: begin
        k = (k ^ LANE3_XOR) + (k << 6);
        k = k ^ (k >> 9);
        k = k * LANE3_MUL;
        k = k ^ (k >> 14);
      end
    endcase
    return k;
  endfunction

  // Result of one accepted item; updates the model filter and count.
  task automatic predict_outcome(input in_item_t it, output out_item_t r);
    int  slot [NUM_HASH];
    logic all_set;
    r = '0;
    all_set = 1'b1;
    if (it.req_type == REQ_CLEAR) begin
      // clears even while disabled
      filt_m = '0;
      count_m = '0;
      r.was_cleared = 1'b1;
    end else if ((it.req_type == REQ_PREDICT || it.req_type == REQ_UPDATE) && en_m) begin
      for (int l = 0; l < NUM_HASH; l++) begin
        slot[l] = int'(lane_hash(l, it.address) % 64'(FILTER_BITS));
        all_set = all_set & filt_m[slot[l]];
      end
      r.present = all_set;
      // only a real hit on an absent address inserts and counts
      if (it.req_type == REQ_UPDATE && it.actual_hit && !all_set) begin
        for (int l = 0; l < NUM_HASH; l++) filt_m[slot[l]] = 1'b1;
        count_m = count_m + 1'b1;
        if (count_m > COUNT_W'(max_m)) begin
          filt_m = '0;
          count_m = '0;
          r.was_cleared = 1'b1;
        end
      end
    end
    // unused request type and disabled accesses leave r at zero
  endtask

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------

  function automatic void add_access(logic [1:0] req, logic [63:0] addr, logic hit);
    step_t s;
    s.kind = STEP_ITEM;
    s.item = '{req_type: req, address: addr, actual_hit: hit};
    s.idx  = '0;
    s.data = '0;
    step_q.push_back(s);
  endfunction

  function automatic void add_reg_write(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    step_t s;
    s.kind = STEP_CFG;
    s.item = '0;
    s.idx  = idx;
    s.data = data;
    step_q.push_back(s);
  endfunction

  // sender holds off until every outstanding result has come back
  function automatic void add_pause();
    step_t s;
    s.kind = STEP_DRAIN;
    s.item = '0;
    s.idx  = '0;
    s.data = '0;
    step_q.push_back(s);
  endfunction

  // Mostly inserts and lookups on a small address pool so that entries
  // really get set and found; the rest are random addresses, clears and
  // unused codes.
  function automatic void add_traffic(int n);
    int          sel;
    logic [63:0] a;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (sel < 45)
        add_access(REQ_UPDATE, a, ($urandom_range(0, 9) != 0));
      else if (sel < 78)
        add_access(REQ_PREDICT, a, 1'($urandom));
      else if (sel < 86)
        add_access(REQ_PREDICT, {$urandom, $urandom}, 1'($urandom));
      else if (sel < 93)
        add_access(REQ_UPDATE, {$urandom, $urandom}, 1'($urandom));
      else if (sel < 96)
        add_access(REQ_CLEAR, {$urandom, $urandom}, 1'($urandom));
      else
        add_access(REQ_UNUSED, {$urandom, $urandom}, 1'($urandom));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued items, performs register writes when idle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic      hold_start;
    logic      wr;
    out_item_t res;
    step_t     nxt;
    hold_start = start;
    wr = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        // item taken on this edge: predict it now, in acceptance order
        predict_outcome(in_item, res);
        outcome_q.push_back('{res: res, seq: items_taken, src: in_item});
        items_taken <= items_taken + 1;
        hold_start = 1'b0;
        // gap before the next item; occasional back-to-back stretches
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
        end
      end
      // idle: nothing outstanding, no item offered, block not sweeping
      if (items_taken == outcomes_seen && !busy && !start)
        idle_run++;
      else
        idle_run = 0;
      if (!hold_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (step_q.size() > 0) begin
          nxt = step_q[0];
          case (nxt.kind)
            STEP_ITEM: begin
              in_item <= nxt.item;
              hold_start = 1'b1;
              void'(step_q.pop_front());
            end
            STEP_CFG: begin
              if (idle_run >= SETTLE_CYCLES) begin
                wr = 1'b1;
                cfg_index <= nxt.idx;
                cfg_wdata <= nxt.data;
                case (nxt.idx)
                  CFG_ENABLE:      en_m = nxt.data[0];
                  CFG_MAX_ENTRIES: max_m = nxt.data;
                  default: ;
                endcase
                void'(step_q.pop_front());
              end
            end
            STEP_DRAIN: begin
              if (idle_run >= SETTLE_CYCLES) void'(step_q.pop_front());
            end
            default: ;
          endcase
        end
      end
    end
    start  <= hold_start;
    cfg_we <= wr;
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobed result is matched against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      outcomes_seen <= outcomes_seen + 1;
      if (outcome_q.size() == 0) begin
        note_error($sformatf("unexpected result present=%0b was_cleared=%0b",
                             out_item.present, out_item.was_cleared));
      end else begin
        e = outcome_q.pop_front();
        if (out_item.present !== e.res.present)
          note_error($sformatf("item %0d (req %0d addr %h hit %0b): present exp %0b got %0b",
                               e.seq, e.src.req_type, e.src.address, e.src.actual_hit,
                               e.res.present, out_item.present));
        if (out_item.was_cleared !== e.res.was_cleared)
          note_error($sformatf("item %0d (req %0d addr %h hit %0b): was_cleared exp %0b got %0b",
                               e.seq, e.src.req_type, e.src.address, e.src.actual_hit,
                               e.res.was_cleared, out_item.was_cleared));
      end
    end
  end

  // Watchdog: cycles with neither an item taken nor a result shown
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid)
        stall_cyc <= 0;
      else
        stall_cyc <= stall_cyc + 1;
      if (stall_cyc >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] lim;

    // directed part, reset register values first
    add_access(REQ_PREDICT, 64'h0, 1'b0);             // empty filter
    add_access(REQ_UPDATE,  64'h0, 1'b0);             // miss outcome, no insert
    add_access(REQ_UPDATE,  64'h0, 1'b1);             // insert
    add_access(REQ_PREDICT, 64'h0, 1'b0);             // now present
    add_access(REQ_UPDATE,  64'h0, 1'b1);             // already present, no count
    add_access(REQ_UPDATE,  '1, 1'b1);
    add_access(REQ_PREDICT, '1, 1'b1);
    add_access(REQ_UPDATE,  64'h8000_0000_0000_0001, 1'b1);
    add_access(REQ_UNUSED,  '1, 1'b1);                 // ignored code
    add_access(REQ_UNUSED,  64'h0, 1'b0);
    add_access(REQ_CLEAR,   64'h0, 1'b0);
    add_access(REQ_PREDICT, '1, 1'b0);                 // gone after clear
    add_pause();
    // disabled: lookups miss, updates do nothing, clear still works
    add_reg_write(CFG_ENABLE, '0);
    add_access(REQ_UPDATE,  64'h1234_5678_9abc_def0, 1'b1);
    add_access(REQ_PREDICT, 64'h1234_5678_9abc_def0, 1'b0);
    add_access(REQ_CLEAR,   '1, 1'b1);
    add_reg_write(CFG_ENABLE, 20'd1);
    // no entries allowed: first insert overflows at once
    add_reg_write(CFG_MAX_ENTRIES, '0);
    add_access(REQ_UPDATE,  64'h5555_5555_5555_5555, 1'b1);
    add_access(REQ_PREDICT, 64'h5555_5555_5555_5555, 1'b0);
    // fill at the widest limit, then lower it below the count
    add_reg_write(CFG_MAX_ENTRIES, '1);
    add_access(REQ_UPDATE,  64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    add_access(REQ_UPDATE,  64'h0123_4567_89ab_cdef, 1'b1);
    add_access(REQ_UPDATE,  64'hfedc_ba98_7654_3210, 1'b1);
    add_reg_write(CFG_MAX_ENTRIES, 20'd1);
    add_access(REQ_UPDATE,  64'h0f0f_0f0f_0f0f_0f0f, 1'b1); // overflows
    add_access(REQ_PREDICT, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = {$urandom, $urandom};
      case (p % 6)
        0: lim = CFG_DATA_W'($urandom_range(2, 30));
        1: lim = '0;
        2: lim = '1;
        3: lim = CFG_DATA_W'($urandom_range(1, 8));
        4: lim = 20'd1024;
        default: lim = CFG_DATA_W'($urandom);
      endcase
      add_pause();
      add_reg_write(CFG_ENABLE, (p == 4) ? '0 : 20'd1);
      add_reg_write(CFG_MAX_ENTRIES, lim);
      add_traffic(PHASE_ITEMS / 2);
      if (p == 3) add_pause();
      add_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (step_q.size() != 0 || items_taken != outcomes_seen) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0)
      note_error($sformatf("%0d results never arrived", outcome_q.size()));
    if (err_cnt == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

### filelist.f
src/bfhp_pkg.sv
src/bfhp_hash.sv
src/bfhp_mod.sv
src/bfhp_filter.sv
src/bloom_filter_hit_predictor_core.sv
verif/tb_top.sv
